// ----- sv/rlm_pkg.sv -----
// Shared types and fixed widths for the RMS level meter.
// No dependencies; imported by block_rms_level_meter_core and the testbench.
package rlm_pkg;

	// Field widths fixed by the stream format.
	localparam int SAMPLE_W   = 24;
	localparam int LEVEL_W    = 24;
	localparam int COUNT_W    = 13;
	localparam int SQ_W       = 47;
	localparam int RAD_W      = 48;
	localparam int SQ_REM_W   = 27;
	localparam int SQRT_STEPS = 24;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 40;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DRAIN = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_SQRT  = 5'b01000,
		ST_OUT   = 5'b10000
	} rlm_state_t;

endpackage

// ----- sv/rlm_cmp_sub.sv -----
// Shared compare-and-subtract unit for the divide and square root steps.
// Depends on nothing; used by block_rms_level_meter_core.
module rlm_cmp_sub #(
	parameter int W = 27
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	// One wide subtract; the borrow out tells whether a >= b.
	logic [W:0] sub_w;

	always_comb begin
		sub_w = {1'b0, a} - {1'b0, b};
		ge    = ~sub_w[W];
		diff  = sub_w[W-1:0];
	end

endmodule

// ----- sv/block_rms_level_meter_core.sv -----
// RMS level meter top level: squaring front end, accumulator and sequencer.
// Depends on rlm_pkg and rlm_cmp_sub.
//
// Usage: samples arrive on the s_ channel, one signed 24-bit sample per word,
// with s_tlast on the final sample of a block. Each sample is squared and
// added to a running sum at one word per cycle while s_tready is high. Samples
// beyond MAX_SAMPLES in a block are dropped and flagged. The word with s_tlast
// closes the block: s_tready falls and the sum is divided by the sample count
// with a restoring divider (one quotient bit per cycle), then the mean goes
// through a digit-by-digit square root (two radicand bits per cycle). Both use
// the same compare-and-subtract unit. After the last sample the sequencer steps
// through its drain, divide, root and output states; m_tvalid rises once the
// output state loads the result register.
// The result word on m_ carries the level, the count and the overflow flag.
// It sits in an output register; the block returns to accepting samples as
// soon as it is loaded. If the receiver stalls with a result still held,
// the next result waits in the sequencer until the register frees up.
// Reset clears the sum, the count, the flag and the output valid; no
// clearing pass is needed.
module block_rms_level_meter_core
	import rlm_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [23:0] sample
	input  logic                 s_tlast,  // is_last
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // [23:0] rms_level, [36:24] sample_count,
	                                       // [37] overflow, [39:38] zero
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = 46 + CNT_W;
	localparam int UW     = (CNT_W + 1 > SQ_REM_W) ? CNT_W + 1 : SQ_REM_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	rlm_state_t state_q;

	logic [CNT_W-1:0]    cnt_q;
	logic                drop_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_next;
	logic                valid_s1;
	logic                keep_s1;
	logic [SQ_W-1:0]     sq_s1;
	logic                accept;
	logic                keep_now;
	logic [SAMPLE_W-1:0] mag;
	logic [2*SAMPLE_W-1:0] prod;

	logic [SUM_W-1:0]    dq_q;
	logic [RAD_W-1:0]    rad_q;
	logic [LEVEL_W-1:0]  root_q;
	logic [UW-1:0]       rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    div_q;
	logic                ovf_hold_q;

	logic [UW-1:0]       unit_a;
	logic [UW-1:0]       unit_b;
	logic                unit_ge;
	logic [UW-1:0]       unit_diff;
	logic [UW-1:0]       div_shift;
	logic [UW-1:0]       sqrt_shift;
	logic [SUM_W-1:0]    quot_next;

	logic [LEVEL_W-1:0]  level_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic                ovf_out_q;
	logic                m_valid_q;
	logic                load_out;
	logic [CNT_W+COUNT_W-1:0] count_wide;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign keep_now = (cnt_q < CNT_W'(MAX_SAMPLES));
	assign load_out = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	// Magnitude of the sample and its square, registered before the add.
	always_comb begin
		mag  = s_tdata[SAMPLE_W-1] ? (~s_tdata[SAMPLE_W-1:0] + 1'b1) : s_tdata[SAMPLE_W-1:0];
		prod = mag * mag;
	end

	always_ff @(posedge clk) begin
		sq_s1 <= prod[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			keep_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			keep_s1  <= accept && keep_now;
		end
	end

	// Running sum including the square that is in flight.
	assign sum_next = (valid_s1 && keep_s1) ? (sum_q + SUM_W'(sq_s1)) : sum_q;

	// Trial operands for the shared unit.
	always_comb begin
		div_shift  = {rem_q[UW-2:0], dq_q[SUM_W-1]};
		sqrt_shift = {rem_q[UW-3:0], rad_q[RAD_W-1:RAD_W-2]};
		if (state_q == ST_SQRT) begin
			unit_a = sqrt_shift;
			unit_b = UW'({root_q, 2'b01});
		end else begin
			unit_a = div_shift;
			unit_b = UW'(div_q);
		end
		quot_next = {dq_q[SUM_W-2:0], unit_ge};
	end

	rlm_cmp_sub #(
		.W(UW)
	) u_cmp_sub (
		.a   (unit_a),
		.b   (unit_b),
		.ge  (unit_ge),
		.diff(unit_diff)
	);

	// Sequencer: accumulate, divide, take the root, hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			sum_q      <= '0;
			m_valid_q  <= 1'b0;
			step_q     <= '0;
			ovf_hold_q <= 1'b0;
		end else begin
			sum_q <= load_out ? '0 : sum_next;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (keep_now) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// The last square lands in the sum this cycle.
					dq_q       <= sum_next;
					div_q      <= cnt_q;
					ovf_hold_q <= drop_q;
					rem_q      <= '0;
					step_q     <= STEP_W'(SUM_W);
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(1)) begin
						rad_q   <= RAD_W'(quot_next);
						rem_q   <= '0;
						root_q  <= '0;
						step_q  <= STEP_W'(SQRT_STEPS);
						state_q <= ST_SQRT;
					end else begin
						dq_q   <= quot_next;
						rem_q  <= unit_ge ? unit_diff : div_shift;
						step_q <= step_q - 1'b1;
					end
				end
				ST_SQRT: begin
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					rem_q  <= unit_ge ? unit_diff : sqrt_shift;
					root_q <= {root_q[LEVEL_W-2:0], unit_ge};
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						cnt_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register payload.
	assign count_wide = {{COUNT_W{1'b0}}, div_q};

	always_ff @(posedge clk) begin
		if (load_out) begin
			level_q     <= root_q;
			count_out_q <= count_wide[COUNT_W-1:0];
			ovf_out_q   <= ovf_hold_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, ovf_out_q, count_out_q, level_q};

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for block_rms_level_meter_core: sample blocks go in on the
// s_ stream, level words are checked on the m_ stream against a cycle-free predictor.
// Depends on rlm_pkg and the block's RTL.
module testbench
	import rlm_pkg::*;
();

	localparam int unsigned BLOCK_CAP   = 4096;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned DRAIN_LIMIT = 50000;
	localparam int unsigned SETTLE_CYC  = 200;

	// One expected level word, split into its fields.
	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic [COUNT_W-1:0] count;
		logic               ovf;
	} level_word_t;

	// Tracks the running sum of squares and holds the level words still due.
	class level_scoreboard;
		level_word_t levels_due[$];
		bit [63:0]   square_sum;
		int unsigned samples_in_block;
		bit          dropped;
		int unsigned errors;

		function new();
			square_sum       = 0;
			samples_in_block = 0;
			dropped          = 0;
			errors           = 0;
		endfunction

		// Largest r with r*r <= v, built one bit at a time from the top.
		function bit [LEVEL_W-1:0] floor_root(bit [63:0] v);
			bit [LEVEL_W-1:0] r;
			bit [LEVEL_W-1:0] trial;
			r = '0;
			for (int b = LEVEL_W - 1; b >= 0; b--) begin
				trial = r | (LEVEL_W'(1) << b);
				if (64'(trial) * 64'(trial) <= v)
					r = trial;
			end
			return r;
		endfunction

		// Accounts for one accepted sample word; a closing word queues a level.
		function void note_sample(logic [SAMPLE_W-1:0] smp, logic last);
			longint      sx;
			bit [63:0]   mean;
			level_word_t w;
			sx = longint'($signed(smp));
			if (samples_in_block < BLOCK_CAP) begin
				square_sum       += 64'(sx * sx);
				samples_in_block += 1;
			end else begin
				dropped = 1'b1;
			end
			if (last) begin
				mean    = square_sum / 64'(samples_in_block);
				w.level = floor_root(mean);
				w.count = COUNT_W'(samples_in_block);
				w.ovf   = dropped;
				levels_due.push_back(w);
				square_sum       = 0;
				samples_in_block = 0;
				dropped          = 1'b0;
			end
		endfunction

		// Compares one accepted result word with the oldest level due.
		function void check_result(logic [M_TDATA_W-1:0] word);
			level_word_t w;
			if (levels_due.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, word);
				errors++;
				return;
			end
			w = levels_due.pop_front();
			if (word[23:0] !== w.level) begin
				$display("%0t: rms_level expected %0d actual %0d", $time, w.level,
					word[23:0]);
				errors++;
			end
			if (word[36:24] !== w.count) begin
				$display("%0t: sample_count expected %0d actual %0d", $time, w.count,
					word[36:24]);
				errors++;
			end
			if (word[37] !== w.ovf) begin
				$display("%0t: overflow expected %0b actual %0b", $time, w.ovf, word[37]);
				errors++;
			end
		endfunction

		function int pending();
			return levels_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int unsigned tx_idle_pct   = 0;
	int unsigned rx_stall_pct  = 0;
	int unsigned items_sent    = 0;

	level_scoreboard sb = new();

	block_rms_level_meter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver side: stall at random, and check every accepted word.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Sends one sample word, with random idle cycles ahead of it. Starts and ends
	// at a falling edge.
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_TDATA_W'($urandom);
			s_tlast  <= 1'($urandom_range(1));
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(smp, last);
		items_sent++;
		@(negedge clk);
	endtask

	// Draws a sample: fully random, an extreme, near zero, or of large magnitude.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] smp;
		case ($urandom_range(3))
			0: smp = SAMPLE_W'($urandom);
			1: begin
				case ($urandom_range(4))
					0: smp = 24'h800000;
					1: smp = 24'h7FFFFF;
					2: smp = 24'h000000;
					3: smp = 24'hFFFFFF;
					default: smp = 24'h000001;
				endcase
			end
			2: smp = SAMPLE_W'(int'($urandom_range(511)) - 256);
			default: smp = {($urandom_range(1) ? 2'b10 : 2'b01), 22'($urandom)};
		endcase
		return smp;
	endfunction

	// Mostly short blocks, some medium, a few long.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(8, 1);
		else if (r < 95)
			return $urandom_range(40, 9);
		return $urandom_range(200, 41);
	endfunction

	task automatic send_random_block(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_sample(pick_sample(), i == len - 1);
	endtask

	// Holds the sender off until every level due has come out.
	task automatic wait_for_levels();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned waited;
		int unsigned phase_start;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-sample blocks at the field extremes.
		send_sample(24'h000000, 1'b1);
		send_sample(24'h800000, 1'b1);
		send_sample(24'h7FFFFF, 1'b1);
		send_sample(24'hFFFFFF, 1'b1);
		send_sample(24'h000001, 1'b1);
		// Mixed signs and alternating bit patterns.
		send_sample(24'h7FFFFF, 1'b0);
		send_sample(24'h800000, 1'b1);
		send_sample(24'h555555, 1'b0);
		send_sample(24'hAAAAAA, 1'b0);
		send_sample(24'h000000, 1'b1);
		for (int i = 1; i <= 5; i++)
			send_sample(SAMPLE_W'(i), i == 5);
		send_sample(24'hFFFFFE, 1'b0);
		send_sample(24'h000003, 1'b0);
		send_sample(24'hC00000, 1'b1);
		wait_for_levels();

		// Random blocks under four idling patterns.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
				default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				send_random_block(pick_length());
			if (p == 1)
				wait_for_levels();
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d level words never arrived", $time, sb.pending());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("block_rms_level_meter_core: match");
		else
			$display("block_rms_level_meter_core: mismatch");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("block_rms_level_meter_core: mismatch");
		$finish;
	end

endmodule
